// File: rtl/core/iiee_pkg.sv
// Shared constants and types of the infix integer expression evaluator.
`timescale 1ns / 1ps
`default_nettype none
package iiee_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int RESULT_WIDTH = 32;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQUAL = 8'h3D;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_MUL  = 2'd1;
	localparam logic [1:0] OP_DIV  = 2'd2;

	typedef struct packed {
		logic start;
		logic is_div;
	} unit_req_t;

endpackage
`default_nettype wire

// File: rtl/core/iiee_unit.sv
// Iterative shift-add multiplier and restoring divider built around one shared adder.
`timescale 1ns / 1ps
`default_nettype none
module iiee_unit #(
	parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire iiee_pkg::unit_req_t    req,
	input  wire logic [DATA_WIDTH-1:0]  opa,
	input  wire logic [DATA_WIDTH-1:0]  opb,
	output logic                        done,
	output logic [DATA_WIDTH-1:0]       result
);
	import iiee_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_MUL  = 2'd1;
	localparam logic [1:0] U_DIV  = 2'd2;
	localparam logic [1:0] U_FIX  = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  mcand_q;
	logic [W-1:0]  mplier_q;
	logic          neg_q;
	logic          div_q;

	logic [W:0]    add_x;
	logic [W:0]    add_y;
	logic          add_sub;
	logic [W+1:0]  add_sum;
	logic          ge;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;

	assign mag_a = opa[W-1] ? W'(-opa) : opa;
	assign mag_b = opb[W-1] ? W'(-opb) : opb;

	always_comb begin
		if (state_q == U_DIV) begin
			add_x = {acc_q, mplier_q[W-1]};
			add_y = {1'b0, mcand_q};
			add_sub = 1'b1;
		end else begin
			add_x = {1'b0, acc_q};
			add_y = {1'b0, mcand_q};
			add_sub = 1'b0;
		end
		add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (W+2)'(add_sub);
	end

	assign ge = add_sum[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				U_IDLE: begin
					if (req.start) begin
						state_q <= req.is_div ? U_DIV : U_MUL;
						cnt_q <= LAST_STEP;
					end
				end
				U_MUL, U_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= U_FIX;
					end
				end
				U_FIX: begin
					state_q <= U_IDLE;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					acc_q <= '0;
					div_q <= req.is_div;
					if (req.is_div) begin
						mcand_q <= mag_b;
						mplier_q <= mag_a;
						neg_q <= opa[W-1] ^ opb[W-1];
					end else begin
						mcand_q <= opa;
						mplier_q <= opb;
						neg_q <= 1'b0;
					end
				end
			end
			U_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= add_sum[W-1:0];
				end
				mcand_q <= {mcand_q[W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[W-1:1]};
			end
			U_DIV: begin
				acc_q <= ge ? add_sum[W-1:0] : add_x[W-1:0];
				mplier_q <= {mplier_q[W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == U_FIX);

	always_comb begin
		if (div_q) begin
			result = neg_q ? W'(-mplier_q) : mplier_q;
		end else begin
			result = acc_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/infix_integer_expression_evaluator.sv
// Top level of the infix integer expression evaluator: character decode, sequencer and state.
// A digit or an ignored character is taken without leaving the idle state; an operator or '='
// that closes a plain term or a division by zero passes through the apply state; one that closes
// a product or a quotient first waits in the unit state for the bit-serial multiply/divide unit.
// One item is taken at a time, none while the last is in progress; '=' also waits while
// an earlier result is unaccepted. Reset: arst_n clears state and output register at once.
`timescale 1ns / 1ps
`default_nettype none
module infix_integer_expression_evaluator #(
	parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [iiee_pkg::RESULT_WIDTH-1:0] result_value,
	output logic             div_zero_error
);
	import iiee_pkg::*;

	localparam int W = DATA_WIDTH;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_UNIT  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;

	localparam logic [1:0] ACT_TERM = 2'd0;
	localparam logic [1:0] ACT_SUM  = 2'd1;
	localparam logic [1:0] ACT_EQ   = 2'd2;

	logic [1:0]   state_q;
	logic [1:0]   act_q;
	logic [W-1:0] number_q;
	logic [W-1:0] term_q;
	logic [1:0]   pend_q;
	logic [W-1:0] sum_q;
	logic         neg_q;
	logic         new_neg_q;
	logic         err_q;
	logic [W-1:0] t_q;
	logic         out_valid_q;
	logic [RESULT_WIDTH-1:0] result_q;
	logic         div_err_q;

	logic         accept;
	logic         is_digit;
	logic         is_term_op;
	logic         is_sum_op;
	logic         is_eq;
	logic         closing;
	logic         pend_div;
	logic         num_zero;
	logic         need_unit;
	logic [3:0]   digit;
	logic [W-1:0] num_next;
	logic [W-1:0] sum_next;
	logic [RESULT_WIDTH-1:0] sum_ext;
	logic         out_free;
	logic         emit;
	unit_req_t    req;
	logic         unit_done;
	logic [W-1:0] unit_result;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;

	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_term_op = (char_code == CH_STAR) || (char_code == CH_SLASH);
	assign is_sum_op = (char_code == CH_PLUS) || (char_code == CH_MINUS);
	assign is_eq = (char_code == CH_EQUAL);
	assign closing = is_term_op || is_sum_op || is_eq;
	assign pend_div = (pend_q == OP_DIV);
	assign num_zero = (number_q == '0);
	assign need_unit = closing && ((pend_q == OP_MUL) || (pend_div && !num_zero));

	assign digit = 4'(char_code - CH_ZERO);
	assign num_next = W'({number_q, 3'b000}) + W'({number_q, 1'b0}) + W'(digit);

	assign req.start = accept && need_unit;
	assign req.is_div = pend_div;

	assign sum_next = neg_q ? W'(sum_q - t_q) : W'(sum_q + t_q);
	assign out_free = !out_valid_q || out_ready;
	assign emit = (state_q == S_APPLY) && (act_q == ACT_EQ) && out_free;

	generate
		if (W >= RESULT_WIDTH) begin : g_trunc
			assign sum_ext = sum_next[RESULT_WIDTH-1:0];
		end else begin : g_sext
			assign sum_ext = {{(RESULT_WIDTH-W){sum_next[W-1]}}, sum_next};
		end
	endgenerate

	iiee_unit #(
		.DATA_WIDTH(W)
	) u_unit (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.opa(term_q),
		.opb(number_q),
		.done(unit_done),
		.result(unit_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACT_TERM;
			number_q <= '0;
			term_q <= '0;
			pend_q <= OP_NONE;
			sum_q <= '0;
			neg_q <= 1'b0;
			new_neg_q <= 1'b0;
			err_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_digit) begin
							number_q <= num_next;
						end else if (closing) begin
							number_q <= '0;
							new_neg_q <= (char_code == CH_MINUS);
							if (is_term_op) begin
								act_q <= ACT_TERM;
								pend_q <= (char_code == CH_STAR) ? OP_MUL : OP_DIV;
							end else if (is_sum_op) begin
								act_q <= ACT_SUM;
							end else begin
								act_q <= ACT_EQ;
							end
							if (pend_div && num_zero) begin
								err_q <= 1'b1;
							end
							state_q <= need_unit ? S_UNIT : S_APPLY;
						end
					end
				end
				S_UNIT: begin
					if (unit_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					case (act_q)
						ACT_TERM: begin
							term_q <= t_q;
							state_q <= S_IDLE;
						end
						ACT_SUM: begin
							sum_q <= sum_next;
							neg_q <= new_neg_q;
							pend_q <= OP_NONE;
							term_q <= '0;
							state_q <= S_IDLE;
						end
						ACT_EQ: begin
							if (out_free) begin
								sum_q <= '0;
								neg_q <= 1'b0;
								pend_q <= OP_NONE;
								term_q <= '0;
								err_q <= 1'b0;
								state_q <= S_IDLE;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			result_q <= '0;
			div_err_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			result_q <= sum_ext;
			div_err_q <= err_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && closing && !need_unit) begin
			t_q <= pend_div ? '0 : number_q;
		end else if (state_q == S_UNIT && unit_done) begin
			t_q <= unit_result;
		end
	end

	assign out_valid = out_valid_q;
	assign result_value = result_q;
	assign div_zero_error = div_err_q;

	a_done_in_unit: assert property (@(posedge clk) disable iff (!arst_n)
		unit_done |-> (state_q == S_UNIT))
		else $error("unit finished outside of the wait state");

	a_eq_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_eq) |=> !in_ready)
		else $error("equal sign item did not occupy the sequencer");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (out_valid_q && sum_q == '0 && !err_q && pend_q == OP_NONE))
		else $error("expression state not cleared after result");

endmodule
`default_nettype wire
